// ===== sv/bwsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------------------------
// Boundary wire monitor package
// Shared types, register indexes, reset values and the pin decode table.
// ------------------------------------------------------------------------------------------
package bwsm_pkg;

	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;

	localparam logic [15:0] SAMPLE_INTERVAL_RST   = 16'h045C;
	localparam logic [6:0]  WINDOW_SIZE_RST       = 7'd100;
	localparam logic [6:0]  OUTSIDE_THRESHOLD_RST = 7'd95;
	localparam logic [7:0]  QUALITY_NONE          = 8'hFF;

	localparam logic [7:0] CODE_O = 8'h4F;
	localparam logic [7:0] CODE_N = 8'h4E;
	localparam logic [7:0] CODE_I = 8'h49;
	localparam logic [7:0] CODE_H = 8'h48;

	typedef enum logic {
		OP_POLL  = 1'b0,
		OP_STATS = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		PH_RAISE  = 2'd0,
		PH_LOWER  = 2'd1,
		PH_DECODE = 2'd2
	} phase_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SAMPLE_INTERVAL   = 2'd0,
		REG_WINDOW_SIZE       = 2'd1,
		REG_OUTSIDE_THRESHOLD = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [1:0]  pin_bits;
		logic [31:0] tick;
		logic        zone_enable;
	} item_t;

	typedef struct packed {
		logic [15:0] sample_interval;
		logic [6:0]  window_size;
		logic [6:0]  outside_threshold;
	} cfg_t;

	typedef struct packed {
		logic       detector_drive;
		logic       right_flag;
		logic       boundary_flag;
		logic       left_flag;
		logic [7:0] signal_code;
		logic [7:0] quality;
		logic [6:0] samples_in_window;
		logic       outside;
		logic       sample_taken;
	} result_t;

	// The two detector pins map onto one of four ASCII signal codes.
	function automatic logic [7:0] pin_code(input logic [1:0] pins);
		logic [7:0] code;
		case (pins)
			2'd0:    code = CODE_O;
			2'd1:    code = CODE_N;
			2'd2:    code = CODE_I;
			2'd3:    code = CODE_H;
			default: code = CODE_O;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

// ===== sv/bwsm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------------------------
// Boundary wire monitor input channel
// Valid/ready channel carrying one poll or statistics request word.
// ------------------------------------------------------------------------------------------
interface bwsm_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [1:0]  pin_bits;
	logic [31:0] tick;
	logic        zone_enable;

	modport source(output valid, output opcode, output pin_bits, output tick,
		output zone_enable, input ready);
	modport sink(input valid, input opcode, input pin_bits, input tick,
		input zone_enable, output ready);
endinterface
`default_nettype wire

// ===== sv/bwsm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------------------------
// Boundary wire monitor result channel
// Valid/ready channel carrying one status word per request.
// ------------------------------------------------------------------------------------------
interface bwsm_out_if;
	logic       valid;
	logic       ready;
	logic       detector_drive;
	logic       right_flag;
	logic       boundary_flag;
	logic       left_flag;
	logic [7:0] signal_code;
	logic [7:0] quality;
	logic [6:0] samples_in_window;
	logic       outside;
	logic       sample_taken;

	modport source(output valid, output detector_drive, output right_flag,
		output boundary_flag, output left_flag, output signal_code, output quality,
		output samples_in_window, output outside, output sample_taken, input ready);
	modport sink(input valid, input detector_drive, input right_flag,
		input boundary_flag, input left_flag, input signal_code, input quality,
		input samples_in_window, input outside, input sample_taken, output ready);
endinterface
`default_nettype wire

// ===== sv/bwsm_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------------------------
// Boundary wire monitor configuration channel
// Valid/ready register write channel with an index and write data.
// ------------------------------------------------------------------------------------------
interface bwsm_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bwsm_pkg::CfgIdxW-1:0]  index;
	logic [bwsm_pkg::CfgDataW-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/bwsm_state.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------------------------
// Boundary wire monitor state
// Holds the poll and window state and works out the next state and status word.
// ------------------------------------------------------------------------------------------
module bwsm_state (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire bwsm_pkg::item_t   item,
	input  wire bwsm_pkg::cfg_t    cfg,
	output bwsm_pkg::result_t      result
);

	bwsm_pkg::phase_t phase_q, phase_d;
	logic        drive_q, drive_d;
	logic        right_q, right_d;
	logic        bound_q, bound_d;
	logic        left_q, left_d;
	logic [7:0]  code_q, code_d;
	logic [7:0]  quality_q, quality_d;
	logic [6:0]  sample_cnt_q, sample_cnt_d;
	logic [6:0]  miss_cnt_q, miss_cnt_d;
	logic        outside_q, outside_d;
	logic [31:0] last_tick_q, last_tick_d;
	logic        taken;

	logic [31:0] gap;
	logic        gate_open;
	logic [6:0]  miss_inc;
	logic [6:0]  cnt_inc;
	logic [7:0]  miss_plus_thr;
	logic [7:0]  pin_ascii;

	assign gap           = item.tick - last_tick_q;
	assign gate_open     = gap > {16'd0, cfg.sample_interval};
	assign miss_inc      = miss_cnt_q + {6'd0, (!right_q && !left_q)};
	assign cnt_inc       = sample_cnt_q + 7'd1;
	assign miss_plus_thr = {1'b0, miss_inc} + {1'b0, cfg.outside_threshold};
	assign pin_ascii     = bwsm_pkg::pin_code(item.pin_bits);

	always_comb begin
		phase_d      = phase_q;
		drive_d      = drive_q;
		right_d      = right_q;
		bound_d      = bound_q;
		left_d       = left_q;
		code_d       = code_q;
		quality_d    = quality_q;
		sample_cnt_d = sample_cnt_q;
		miss_cnt_d   = miss_cnt_q;
		outside_d    = outside_q;
		last_tick_d  = last_tick_q;
		taken        = 1'b0;
		case (item.opcode)
			bwsm_pkg::OP_POLL: begin
				case (phase_q)
					bwsm_pkg::PH_RAISE: begin
						drive_d = 1'b1;
						right_d = 1'b0;
						bound_d = 1'b0;
						left_d  = 1'b0;
						phase_d = bwsm_pkg::PH_LOWER;
					end
					bwsm_pkg::PH_LOWER: begin
						drive_d = 1'b0;
						phase_d = bwsm_pkg::PH_DECODE;
					end
					bwsm_pkg::PH_DECODE: begin
						code_d  = pin_ascii;
						phase_d = bwsm_pkg::PH_RAISE;
						case (pin_ascii)
							bwsm_pkg::CODE_H: begin
								right_d = 1'b1;
								bound_d = 1'b0;
							end
							bwsm_pkg::CODE_I: begin
								left_d  = 1'b1;
								bound_d = 1'b1;
								right_d = 1'b0;
							end
							bwsm_pkg::CODE_N: begin
								right_d = 1'b0;
								bound_d = 1'b0;
							end
							default: begin
								left_d  = 1'b0;
								bound_d = 1'b1;
								right_d = 1'b0;
							end
						endcase
					end
					default: begin
						phase_d = bwsm_pkg::PH_RAISE;
					end
				endcase
			end
			bwsm_pkg::OP_STATS: begin
				if (gate_open) begin
					taken        = 1'b1;
					last_tick_d  = item.tick;
					miss_cnt_d   = miss_inc;
					sample_cnt_d = cnt_inc;
					if (cnt_inc >= cfg.window_size) begin
						quality_d    = (miss_inc > cfg.window_size) ? 8'd0 :
							{1'b0, cfg.window_size - miss_inc};
						sample_cnt_d = 7'd0;
						miss_cnt_d   = 7'd0;
						// Misses plus threshold reaching the window covers a threshold
						// above the window size as well.
						outside_d    = item.zone_enable &&
							(miss_plus_thr >= {1'b0, cfg.window_size});
					end
				end
			end
			default: begin
				taken = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= bwsm_pkg::PH_RAISE;
			drive_q      <= 1'b0;
			right_q      <= 1'b0;
			bound_q      <= 1'b0;
			left_q       <= 1'b0;
			code_q       <= 8'd0;
			quality_q    <= bwsm_pkg::QUALITY_NONE;
			sample_cnt_q <= 7'd0;
			miss_cnt_q   <= 7'd0;
			outside_q    <= 1'b0;
			last_tick_q  <= 32'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			drive_q      <= drive_d;
			right_q      <= right_d;
			bound_q      <= bound_d;
			left_q       <= left_d;
			code_q       <= code_d;
			quality_q    <= quality_d;
			sample_cnt_q <= sample_cnt_d;
			miss_cnt_q   <= miss_cnt_d;
			outside_q    <= outside_d;
			last_tick_q  <= last_tick_d;
		end
	end

	assign result.detector_drive    = drive_d;
	assign result.right_flag        = right_d;
	assign result.boundary_flag     = bound_d;
	assign result.left_flag         = left_d;
	assign result.signal_code       = code_d;
	assign result.quality           = quality_d;
	assign result.samples_in_window = sample_cnt_d;
	assign result.outside           = outside_d;
	assign result.sample_taken      = taken;

	// The drive is only ever left high while waiting for the lowering step.
	a_drive_phase: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q |-> (phase_q == bwsm_pkg::PH_LOWER))
		else $error("detector drive high outside the lowering phase");

	// A single decode never reports the wire on both sides.
	a_sides_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(right_q && left_q))
		else $error("right and left flags both set");

	a_boundary_right: assert property (@(posedge clk) disable iff (!arst_n)
		bound_q |-> !right_q)
		else $error("boundary flag set together with right flag");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(sample_cnt_q) && $stable(last_tick_q) && $stable(phase_q)))
		else $error("state moved without an item");

endmodule
`default_nettype wire

// ===== sv/boundary_wire_signal_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------------------------
// Boundary wire signal monitor
// Poll sequencer and signal quality statistics for a boundary wire detector.
// ------------------------------------------------------------------------------------------
// Every request word gives exactly one status word, in order. A request is held in an input
// register, the state update is a short piece of logic, and the status word lands in an
// output register; the block takes one word per clock while the result side is ready, and each
// status word passes through the input register and then the output register before it can be
// taken. Throughput is set by the single state update per cycle, since each word sees the
// state left by the word before it. The input register can accept a new word while a finished
// status word waits in the output register only when the input register is empty.
// A poll word (opcode 0) steps the detector through raise, lower and decode; a statistics
// word (opcode 1) is counted only when the tick has moved on by more than sample_interval
// since the last counted sample. Configuration writes are always accepted and take effect on
// the next word; they should only be made while no word is in flight. A write to the unused
// index is acknowledged and ignored.
// ------------------------------------------------------------------------------------------
module boundary_wire_signal_monitor (
	input  wire logic clk,
	input  wire logic arst_n,
	bwsm_in_if.sink   in_ch,
	bwsm_out_if.source out_ch,
	bwsm_cfg_if.sink  cfg_ch
);

	// Configuration registers.
	bwsm_pkg::cfg_t cfg_q;

	// Input stage.
	logic             valid_s1;
	bwsm_pkg::item_t  item_s1;

	// Output stage.
	logic              valid_s2;
	bwsm_pkg::result_t result_s2;

	bwsm_pkg::result_t result_nxt;
	logic              adv_s1;
	logic              free_s2;

	// The output register can take a new word when it is empty or being drained.
	assign free_s2 = !valid_s2 || out_ch.ready;
	// The word in the input stage moves on, and updates the state, whenever it has room.
	assign adv_s1  = valid_s1 && free_s2;

	assign in_ch.ready  = !valid_s1 || free_s2;
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_interval   <= bwsm_pkg::SAMPLE_INTERVAL_RST;
			cfg_q.window_size       <= bwsm_pkg::WINDOW_SIZE_RST;
			cfg_q.outside_threshold <= bwsm_pkg::OUTSIDE_THRESHOLD_RST;
		end else if (cfg_ch.valid) begin
			case (bwsm_pkg::cfg_reg_t'(cfg_ch.index))
				bwsm_pkg::REG_SAMPLE_INTERVAL: begin
					cfg_q.sample_interval <= cfg_ch.data;
				end
				bwsm_pkg::REG_WINDOW_SIZE: begin
					cfg_q.window_size <= cfg_ch.data[6:0];
				end
				bwsm_pkg::REG_OUTSIDE_THRESHOLD: begin
					cfg_q.outside_threshold <= cfg_ch.data[6:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.opcode      <= bwsm_pkg::opcode_t'(in_ch.opcode);
			item_s1.pin_bits    <= in_ch.pin_bits;
			item_s1.tick        <= in_ch.tick;
			item_s1.zone_enable <= in_ch.zone_enable;
		end
	end

	bwsm_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result_nxt;
		end
	end

	assign out_ch.valid             = valid_s2;
	assign out_ch.detector_drive    = result_s2.detector_drive;
	assign out_ch.right_flag        = result_s2.right_flag;
	assign out_ch.boundary_flag     = result_s2.boundary_flag;
	assign out_ch.left_flag         = result_s2.left_flag;
	assign out_ch.signal_code       = result_s2.signal_code;
	assign out_ch.quality           = result_s2.quality;
	assign out_ch.samples_in_window = result_s2.samples_in_window;
	assign out_ch.outside           = result_s2.outside;
	assign out_ch.sample_taken      = result_s2.sample_taken;

	// A waiting status word is never overwritten by the word behind it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ch.ready) |-> !adv_s1)
		else $error("status word overwritten while stalled");

	// A poll word never reports a counted sample.
	a_taken_stats: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && item_s1.opcode == bwsm_pkg::OP_POLL) |=> !result_s2.sample_taken)
		else $error("poll word marked as sample taken");

	// Words pass through the input stage in order: a held word stays until it moves on.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(item_s1)))
		else $error("input stage lost a word");

endmodule
`default_nettype wire
